// ===== hdl/bdq_pkg.sv =====
// Shared types, codes and field layout for the bounded deque with delete.
package bdq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int MAX_DATA_W     = 64;

   localparam int OP_W        = 3;
   localparam int VALUE_W     = 32;
   localparam int WORD_W      = 32;
   localparam int OCC_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int OP_LSB      = 0;
   localparam int VALUE_LSB   = OP_LSB + OP_W;
   localparam int WORD_LSB    = 0;
   localparam int OCC_LSB     = WORD_LSB + WORD_W;
   localparam int STATUS_LSB  = OCC_LSB + OCC_W;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_BACK   = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_DELETE     = 3'd4,
      OP_COUNT      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;         // latch the accepted request
      logic exec;         // run push, pop or count; clear the scan index
      logic idx_inc;      // advance the scan index
      logic scan_rd;      // read entry at scan index
      logic move_rd;      // read entry one past scan index
      logic move_wr;      // write read word back at scan index
      logic del_done;     // drop one entry after a matched delete
      logic set_nomatch;  // flag delete without match
      logic rsp_load;     // load the response register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      op_type op;
      logic   hit;
      logic   scan_end;
      logic   move_end;
      logic   rsp_free;
   } sts_type;

endpackage

// ===== hdl/bdq_datapath.sv =====
// Datapath of the deque: entry memory, pointers, scan index and response register.
module bdq_datapath #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bdq_pkg::cmd_type                cmd,
   output bdq_pkg::sts_type                sts,
   input  logic [bdq_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bdq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   // Position relative to the front, wrapped into the circular store.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                             input logic [CW:0]   pos);
      logic [CW:0] sum;
      sum = (CW + 1)'(front) + pos;
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[AW-1:0];
   endfunction

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   bdq_pkg::op_type       op_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   bdq_pkg::status_type   status_ff, status_in;
   logic                  pop_ok_ff, pop_ok_in;
   logic                  rsp_valid_ff;
   logic [bdq_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [CW:0]           count_x, idx_x;
   logic                  full, empty;
   logic [bdq_pkg::MAX_DATA_W-1:0] val_wide, word_wide;
   logic [15:0]           occ_wide;
   logic [bdq_pkg::WORD_W-1:0] word_sel;

   assign count_x = {1'b0, count_ff};
   assign idx_x   = {1'b0, idx_ff};
   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);

   always_comb begin
      val_wide = '0;
      val_wide[bdq_pkg::VALUE_W-1:0] = req_tdata[bdq_pkg::VALUE_LSB +: bdq_pkg::VALUE_W];
      word_wide = '0;
      word_wide[DATA_WIDTH-1:0] = rd_data_ff;
      occ_wide = '0;
      occ_wide[CW-1:0] = count_ff;
      word_sel = pop_ok_ff ? word_wide[bdq_pkg::WORD_W-1:0] : '0;
   end

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = val_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;

      if (cmd.exec) begin
         idx_in    = '0;
         status_in = bdq_pkg::ST_OK;
         pop_ok_in = 1'b0;
         case (op_ff)
            bdq_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  status_in = bdq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = slot_of(front_ff, count_x);
                  count_in = count_ff + CW'(1);
               end
            end
            bdq_pkg::OP_POP_BACK: begin
               if (empty) begin
                  status_in = bdq_pkg::ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = slot_of(front_ff, count_x - (CW + 1)'(1));
                  count_in  = count_ff - CW'(1);
                  pop_ok_in = 1'b1;
               end
            end
            bdq_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = bdq_pkg::ST_FULL;
               end else begin
                  front_in = (front_ff == '0) ? LAST_SLOT : front_ff - AW'(1);
                  wr_en    = 1'b1;
                  wr_addr  = front_in;
                  count_in = count_ff + CW'(1);
               end
            end
            bdq_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  status_in = bdq_pkg::ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = front_ff;
                  front_in  = (front_ff == LAST_SLOT) ? '0 : front_ff + AW'(1);
                  count_in  = count_ff - CW'(1);
                  pop_ok_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.scan_rd) begin
         rd_en   = 1'b1;
         rd_addr = slot_of(front_ff, idx_x);
      end
      if (cmd.move_rd) begin
         rd_en   = 1'b1;
         rd_addr = slot_of(front_ff, idx_x + (CW + 1)'(1));
      end
      if (cmd.move_wr) begin
         wr_en   = 1'b1;
         wr_addr = slot_of(front_ff, idx_x);
         wr_data = rd_data_ff;
      end
      if (cmd.del_done) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.set_nomatch) begin
         status_in = bdq_pkg::ST_NOMATCH;
      end
   end

   // Entry store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= bdq_pkg::op_type'(req_tdata[bdq_pkg::OP_LSB +: bdq_pkg::OP_W]);
         val_ff <= val_wide[DATA_WIDTH-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {1'b0, status_ff, occ_wide[bdq_pkg::OCC_W-1:0], word_sel};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         status_ff    <= bdq_pkg::ST_OK;
         pop_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff  <= front_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.op       = op_ff;
   assign sts.hit      = (rd_data_ff == val_ff);
   assign sts.scan_end = (idx_x >= count_x);
   assign sts.move_end = ((idx_x + (CW + 1)'(1)) >= count_x);
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/bdq_ctrl.sv =====
// Controller of the deque: sequences execute, delete scan, close-up and response.
module bdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output bdq_pkg::cmd_type cmd,
   input  bdq_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_MOVE_RD,
      S_MOVE_WR,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = (sts.op == bdq_pkg::OP_DELETE) ? S_SCAN_RD : S_FINISH;
         end
         S_SCAN_RD: begin
            if (sts.scan_end) begin
               cmd.set_nomatch = 1'b1;
               state_in        = S_FINISH;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (sts.hit) begin
               state_in = S_MOVE_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_MOVE_RD: begin
            if (sts.move_end) begin
               cmd.del_done = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.move_rd = 1'b1;
               state_in    = S_MOVE_WR;
            end
         end
         S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_MOVE_RD;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// ===== hdl/bounded_deque_with_delete_core.sv =====
// Top level of the bounded deque with delete: controller, datapath and checks.
//
//  channel | dir | handshake             | payload (lowest bit first)
//  --------+-----+-----------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: opcode[2:0], value[34:3], zero pad
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: word_out[31:0], occupancy[36:32],
//          |     |                       |        status[38:37], zero pad
//
// Push, pop and count go from transfer to a loaded response in these steps:
// accept, execute, load the response register. A delete scans the store from
// the front, a read and a compare per entry, then closes up the tail, a read
// and a write per move, as the entry store has a single read port. Reset is
// synchronous and active high; it clears pointers, count and handshake state,
// while the entry store keeps its content. A stalled response holds in its
// register, and the next request is taken while it waits; the controller holds
// in its final state until the register is free.
module bounded_deque_with_delete_core #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // opcode[2:0], value[34:3], zeros[39:35]
   input  logic [bdq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // word_out[31:0], occupancy[36:32], status[38:37], zero[39]
   output logic [bdq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);

   bdq_pkg::cmd_type cmd;
   bdq_pkg::sts_type sts;

   // Sequence each request through execute, optional scan and close-up, response.
   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Hold the store, front pointer, count and response register.
   bdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A response load must never overwrite a response still waiting.
   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("response loaded over a pending transfer");

   // A close-up write carries the word read in the cycle before.
   a_move_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.move_wr |-> $past(cmd.move_rd))
      else $error("close-up write without a preceding read");

   // Once a request is taken, the controller is busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in progress");

   // The store port serves one operation per cycle.
   a_one_mem_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec, cmd.scan_rd, cmd.move_rd, cmd.move_wr}))
      else $error("conflicting store operations");

endmodule
